// ===== hdl/glyph_cell_rasterizer_5x5_unit_assert.svh =====
// Assertion macros for the glyph cell rasterizer.
// Included by the top level; depends on nothing else.
`ifndef GLYPH_CELL_RASTERIZER_5X5_UNIT_ASSERT_SVH
`define GLYPH_CELL_RASTERIZER_5X5_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define GCR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcr assertion failed");
`define GCR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcr assertion failed");
`else
`define GCR_ASSERT_IMP(label, clk, rst, ante, cons)
`define GCR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/gcr_pkg.sv =====
// Package of the glyph cell rasterizer: widths, glyph ROM, shared structs.
// Used by the interfaces and by every module; depends on nothing.
`timescale 1ns / 1ps

package gcr_pkg;

  localparam int COORD_BITS = 12;
  localparam int SPAN_BITS = COORD_BITS + 2;
  localparam int PIX_BITS = 11;
  localparam int FRAME_BITS = 12;
  localparam int COLOR_BITS = 16;
  localparam int ZOOM_BITS = 4;
  localparam int CODE_BITS = 8;
  localparam int GLYPH_SIDE = 5;
  localparam int GLYPH_CELLS = GLYPH_SIDE * GLYPH_SIDE;
  localparam int GLYPH_COUNT = 41;
  localparam int MAX_ZOOM = 15;
  localparam int FRAME_LIMIT = 2048;
  localparam int FRAME_RESET = 128;
  localparam int CASE_FOLD = 32;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  localparam logic REG_FRAME_WIDTH = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CODE_BITS-1:0] GLYPH_CODE [GLYPH_COUNT] = '{
    8'h20, 8'h2B, 8'h2D, 8'h2E, 8'h25, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
    8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h56, 8'h41, 8'h42, 8'h43, 8'h44,
    8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E,
    8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h57, 8'h58, 8'h59,
    8'h5A
  };

  // Each glyph is five pixel rows; bit b of a row is pixel column 4-b.
  localparam logic [GLYPH_SIDE-1:0] GLYPH_COLS [GLYPH_COUNT][GLYPH_SIDE] = '{
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00}, '{5'h00, 5'h04, 5'h0E, 5'h04, 5'h00},
    '{5'h00, 5'h00, 5'h0E, 5'h00, 5'h00}, '{5'h00, 5'h00, 5'h00, 5'h00, 5'h06},
    '{5'h19, 5'h0A, 5'h04, 5'h0A, 5'h13}, '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h0E}, '{5'h0E, 5'h02, 5'h04, 5'h08, 5'h1F},
    '{5'h0E, 5'h02, 5'h06, 5'h02, 5'h0E}, '{5'h11, 5'h11, 5'h1F, 5'h02, 5'h02},
    '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h1E}, '{5'h0E, 5'h10, 5'h1E, 5'h11, 5'h0E},
    '{5'h1F, 5'h01, 5'h04, 5'h08, 5'h08}, '{5'h0E, 5'h11, 5'h0E, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h0F, 5'h01, 5'h0E}, '{5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04},
    '{5'h0E, 5'h11, 5'h1F, 5'h11, 5'h11}, '{5'h1E, 5'h11, 5'h1E, 5'h11, 5'h1E},
    '{5'h0E, 5'h11, 5'h10, 5'h11, 5'h0E}, '{5'h1C, 5'h12, 5'h11, 5'h12, 5'h1C},
    '{5'h1F, 5'h10, 5'h1E, 5'h10, 5'h1F}, '{5'h1F, 5'h10, 5'h1E, 5'h10, 5'h10},
    '{5'h0E, 5'h10, 5'h17, 5'h11, 5'h0E}, '{5'h11, 5'h11, 5'h1F, 5'h11, 5'h11},
    '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h0E}, '{5'h07, 5'h02, 5'h02, 5'h12, 5'h0C},
    '{5'h11, 5'h12, 5'h1C, 5'h12, 5'h11}, '{5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
    '{5'h11, 5'h1B, 5'h15, 5'h11, 5'h11}, '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11},
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E}, '{5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10},
    '{5'h0E, 5'h11, 5'h15, 5'h12, 5'h0D}, '{5'h1E, 5'h11, 5'h1E, 5'h12, 5'h11},
    '{5'h0E, 5'h10, 5'h0E, 5'h01, 5'h1E}, '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04},
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}, '{5'h11, 5'h11, 5'h15, 5'h1B, 5'h11},
    '{5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11}, '{5'h11, 5'h0A, 5'h04, 5'h04, 5'h04},
    '{5'h1F, 5'h01, 5'h04, 5'h10, 5'h1F}
  };

  typedef struct packed {
    logic [FRAME_BITS-1:0] width;
    logic [FRAME_BITS-1:0] height;
  } frame_cfg_t;

  typedef struct packed {
    logic valid;
    logic on;
    logic last;
    logic [2:0] col;
    logic [2:0] row;
    logic [ZOOM_BITS-1:0] zoom;
    logic see_through;
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic [COLOR_BITS-1:0] fore_color;
    logic [COLOR_BITS-1:0] back_color;
  } cell_job_t;

  // Returns the glyph cells with bit col*5+row set for a lit cell.
  function automatic logic [GLYPH_CELLS-1:0] glyph_lookup(input logic [CODE_BITS-1:0] code);
    logic [CODE_BITS-1:0] key;
    logic [GLYPH_CELLS-1:0] bits;
    key = code;
    bits = '0;
    if (code >= 8'h61 && code <= 8'h7A) begin
      key = code - CODE_BITS'(CASE_FOLD);
    end
    for (int i = 0; i < GLYPH_COUNT; i++) begin
      if (GLYPH_CODE[i] == key) begin
        for (int c = 0; c < GLYPH_SIDE; c++) begin
          bits[c*GLYPH_SIDE +: GLYPH_SIDE] = GLYPH_COLS[i][c];
        end
      end
    end
    return bits;
  endfunction

endpackage

// ===== hdl/gcr_if.sv =====
// Request channel interfaces of the glyph cell rasterizer.
// Depends on gcr_pkg for field widths.
`timescale 1ns / 1ps

interface gcr_cmd_if;
  logic valid;
  logic ready;
  logic [gcr_pkg::CODE_BITS-1:0] char_code;
  logic signed [gcr_pkg::COORD_BITS-1:0] origin_x;
  logic signed [gcr_pkg::COORD_BITS-1:0] origin_y;
  logic [gcr_pkg::ZOOM_BITS-1:0] zoom;
  logic [gcr_pkg::COLOR_BITS-1:0] fore_color;
  logic [gcr_pkg::COLOR_BITS-1:0] back_color;
  logic see_through;

  modport source (
    output valid, char_code, origin_x, origin_y, zoom, fore_color, back_color, see_through,
    input ready
  );
  modport sink (
    input valid, char_code, origin_x, origin_y, zoom, fore_color, back_color, see_through,
    output ready
  );
endinterface

interface gcr_cell_if;
  logic valid;
  logic ready;
  logic write_enable;
  logic [gcr_pkg::PIX_BITS-1:0] x_first;
  logic [gcr_pkg::PIX_BITS-1:0] x_final;
  logic [gcr_pkg::PIX_BITS-1:0] y_first;
  logic [gcr_pkg::PIX_BITS-1:0] y_final;
  logic [gcr_pkg::COLOR_BITS-1:0] cell_color;
  logic last_cell;

  modport source (
    output valid, write_enable, x_first, x_final, y_first, y_final, cell_color, last_cell,
    input ready
  );
  modport sink (
    input valid, write_enable, x_first, x_final, y_first, y_final, cell_color, last_cell,
    output ready
  );
endinterface

// ===== hdl/gcr_cfg_regs.sv =====
// APB register file holding the frame width and height.
// Depends on gcr_pkg.
`timescale 1ns / 1ps

module gcr_cfg_regs (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [gcr_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [gcr_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [gcr_pkg::APB_DATA_BITS-1:0] prdata,
  output logic pready,
  output gcr_pkg::frame_cfg_t frame
);

  logic [gcr_pkg::FRAME_BITS-1:0] frame_width;
  logic [gcr_pkg::FRAME_BITS-1:0] frame_height;
  logic wr_en;
  logic reg_sel;

  assign pready = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= gcr_pkg::FRAME_BITS'(gcr_pkg::FRAME_RESET);
      frame_height <= gcr_pkg::FRAME_BITS'(gcr_pkg::FRAME_RESET);
    end else if (wr_en) begin
      unique case (reg_sel)
        gcr_pkg::REG_FRAME_WIDTH: frame_width <= pwdata[gcr_pkg::FRAME_BITS-1:0];
        gcr_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[gcr_pkg::FRAME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      gcr_pkg::REG_FRAME_WIDTH:
        prdata = {{(gcr_pkg::APB_DATA_BITS-gcr_pkg::FRAME_BITS){1'b0}}, frame_width};
      gcr_pkg::REG_FRAME_HEIGHT:
        prdata = {{(gcr_pkg::APB_DATA_BITS-gcr_pkg::FRAME_BITS){1'b0}}, frame_height};
      default: prdata = '0;
    endcase
  end

  assign frame.width = frame_width;
  assign frame.height = frame_height;

endmodule

// ===== hdl/gcr_cell_seq.sv =====
// Command register and cell walker: looks up the glyph and steps through its 25 cells.
// Depends on gcr_pkg and gcr_cmd_if.
`timescale 1ns / 1ps

module gcr_cell_seq (
  input  logic clk,
  input  logic rst,
  gcr_cmd_if.sink cmd,
  input  logic take,
  output gcr_pkg::cell_job_t job
);

  logic busy;
  logic [2:0] col;
  logic [2:0] row;
  logic [gcr_pkg::GLYPH_CELLS-1:0] held_glyph_bits;
  logic signed [gcr_pkg::COORD_BITS-1:0] held_x;
  logic signed [gcr_pkg::COORD_BITS-1:0] held_y;
  logic [gcr_pkg::ZOOM_BITS-1:0] held_zoom;
  logic held_see;
  logic [gcr_pkg::COLOR_BITS-1:0] held_fore;
  logic [gcr_pkg::COLOR_BITS-1:0] held_back;
  logic row_end;
  logic last;
  logic accept;
  logic [gcr_pkg::ZOOM_BITS-1:0] zoom_sat;

  assign row_end = (row == 3'(gcr_pkg::GLYPH_SIDE - 1));
  assign last = row_end && (col == 3'(gcr_pkg::GLYPH_SIDE - 1));
  assign cmd.ready = !busy || (take && last);
  assign accept = cmd.valid && cmd.ready;
  assign zoom_sat = (cmd.zoom > gcr_pkg::ZOOM_BITS'(gcr_pkg::MAX_ZOOM)) ?
                    gcr_pkg::ZOOM_BITS'(gcr_pkg::MAX_ZOOM) : cmd.zoom;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      col <= '0;
      row <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      col <= '0;
      row <= '0;
    end else if (take) begin
      if (last) begin
        busy <= 1'b0;
      end
      if (row_end) begin
        row <= '0;
        col <= col + 3'd1;
      end else begin
        row <= row + 3'd1;
      end
    end
  end

  // The glyph bits shift down one place per cell, so bit 0 is always the current cell.
  always_ff @(posedge clk) begin
    if (accept) begin
      held_glyph_bits <= gcr_pkg::glyph_lookup(cmd.char_code);
      held_x <= cmd.origin_x;
      held_y <= cmd.origin_y;
      held_zoom <= zoom_sat;
      held_see <= cmd.see_through;
      held_fore <= cmd.fore_color;
      held_back <= cmd.back_color;
    end else if (take) begin
      held_glyph_bits <= held_glyph_bits >> 1;
    end
  end

  always_comb begin
    job.valid = busy;
    job.on = held_glyph_bits[0];
    job.last = last;
    job.col = col;
    job.row = row;
    job.zoom = held_zoom;
    job.see_through = held_see;
    job.origin_x = held_x;
    job.origin_y = held_y;
    job.fore_color = held_fore;
    job.back_color = held_back;
  end

endmodule

// ===== hdl/gcr_cell_calc.sv =====
// Places and clips one cell block and holds it in the result register.
// Depends on gcr_pkg and gcr_cell_if.
`timescale 1ns / 1ps

module gcr_cell_calc (
  input  logic clk,
  input  logic rst,
  input  gcr_pkg::cell_job_t job,
  input  gcr_pkg::frame_cfg_t frame,
  output logic take,
  gcr_cell_if.source cells
);

  localparam int SB = gcr_pkg::SPAN_BITS;
  localparam int PB = gcr_pkg::PIX_BITS;
  localparam int FB = gcr_pkg::FRAME_BITS;
  localparam int OFF_BITS = 7;
  localparam logic signed [SB-1:0] SPAN_ONE = SB'(1);

  typedef struct packed {
    logic ok;
    logic [PB-1:0] lo;
    logic [PB-1:0] hi;
  } span_t;

  function automatic span_t clip_span(input logic signed [SB-1:0] lo,
                                      input logic signed [SB-1:0] hi,
                                      input logic [FB-1:0] lim);
    logic signed [SB-1:0] lim_s;
    logic [FB-1:0] lim_m1;
    span_t r;
    lim_s = $signed({{(SB-FB){1'b0}}, lim});
    lim_m1 = lim - FB'(1);
    r.ok = (lim != '0) && !hi[SB-1] && (lo < lim_s);
    r.lo = lo[SB-1] ? '0 : lo[PB-1:0];
    r.hi = (hi >= lim_s) ? lim_m1[PB-1:0] : hi[PB-1:0];
    return r;
  endfunction

  logic [FB-1:0] lim_x;
  logic [FB-1:0] lim_y;
  logic [2:0] flip_row;
  logic [OFF_BITS-1:0] x_off;
  logic [OFF_BITS-1:0] y_off;
  logic signed [SB-1:0] zoom_s;
  logic signed [SB-1:0] x_lo;
  logic signed [SB-1:0] x_hi;
  logic signed [SB-1:0] y_lo;
  logic signed [SB-1:0] y_hi;
  span_t span_x;
  span_t span_y;
  logic we_next;

  logic out_valid;
  logic out_we;
  logic [PB-1:0] out_x_first;
  logic [PB-1:0] out_x_final;
  logic [PB-1:0] out_y_first;
  logic [PB-1:0] out_y_final;
  logic [gcr_pkg::COLOR_BITS-1:0] out_color;
  logic out_last;

  assign take = job.valid && (!out_valid || cells.ready);

  always_comb begin
    lim_x = (frame.width > FB'(gcr_pkg::FRAME_LIMIT)) ? FB'(gcr_pkg::FRAME_LIMIT) : frame.width;
    lim_y = (frame.height > FB'(gcr_pkg::FRAME_LIMIT)) ? FB'(gcr_pkg::FRAME_LIMIT) : frame.height;
    flip_row = 3'(gcr_pkg::GLYPH_SIDE - 1) - job.row;
    x_off = {4'b0, flip_row} * {3'b0, job.zoom};
    y_off = {4'b0, job.col} * {3'b0, job.zoom};
    zoom_s = $signed({{(SB-gcr_pkg::ZOOM_BITS){1'b0}}, job.zoom});
    x_lo = SB'(job.origin_x) + $signed({{(SB-OFF_BITS){1'b0}}, x_off});
    y_lo = SB'(job.origin_y) + $signed({{(SB-OFF_BITS){1'b0}}, y_off});
    x_hi = x_lo + zoom_s - SPAN_ONE;
    y_hi = y_lo + zoom_s - SPAN_ONE;
    span_x = clip_span(x_lo, x_hi, lim_x);
    span_y = clip_span(y_lo, y_hi, lim_y);
    we_next = (job.zoom != '0) && (job.on || !job.see_through) && span_x.ok && span_y.ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (cells.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_we <= we_next;
      out_x_first <= we_next ? span_x.lo : '0;
      out_x_final <= we_next ? span_x.hi : '0;
      out_y_first <= we_next ? span_y.lo : '0;
      out_y_final <= we_next ? span_y.hi : '0;
      out_color <= we_next ? (job.on ? job.fore_color : job.back_color) : '0;
      out_last <= job.last;
    end
  end

  assign cells.valid = out_valid;
  assign cells.write_enable = out_we;
  assign cells.x_first = out_x_first;
  assign cells.x_final = out_x_final;
  assign cells.y_first = out_y_first;
  assign cells.y_final = out_y_final;
  assign cells.cell_color = out_color;
  assign cells.last_cell = out_last;

endmodule

// ===== hdl/glyph_cell_rasterizer_5x5_unit.sv =====
// Top level of the 5x5 glyph cell rasterizer.
// Depends on gcr_pkg, gcr_if, gcr_cfg_regs, gcr_cell_seq, gcr_cell_calc and the assert header.
//
//   channel  | dir | handshake             | carries
//   ---------+-----+-----------------------+--------------------------------------------
//   cmd      | in  | valid / ready         | char_code, origin, zoom, colors, see_through
//   cells    | out | valid / ready         | write_enable, clipped block, color, last_cell
//   apb      | in  | psel, penable, pready | frame_width, frame_height
//
// Each request produces 25 cell results, one per cycle while the sink is ready.
// The next request is taken in the cycle the 25th cell enters the result register,
// so requests can follow each other without a gap.
// The result register decouples the sides; a stalled sink holds the cell walker.
// Reset is synchronous and leaves both frame registers at 128.
`timescale 1ns / 1ps
`include "glyph_cell_rasterizer_5x5_unit_assert.svh"

module glyph_cell_rasterizer_5x5_unit (
  input  logic clk,
  input  logic rst,
  gcr_cmd_if.sink cmd,
  gcr_cell_if.source cells,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [gcr_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [gcr_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [gcr_pkg::APB_DATA_BITS-1:0] prdata,
  output logic pready
);

  gcr_pkg::frame_cfg_t frame;
  gcr_pkg::cell_job_t job;
  logic take;

  gcr_cfg_regs u_cfg (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .frame(frame)
  );

  gcr_cell_seq u_seq (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .take(take),
    .job(job)
  );

  gcr_cell_calc u_calc (
    .clk(clk),
    .rst(rst),
    .job(job),
    .frame(frame),
    .take(take),
    .cells(cells)
  );

  `GCR_ASSERT_IMP(a_cmd_only_at_end, clk, rst, cmd.valid && cmd.ready && job.valid,
                  job.last && take)
  `GCR_ASSERT_NXT(a_last_cell_out, clk, rst, take && job.last,
                  cells.valid && cells.last_cell)
  `GCR_ASSERT_IMP(a_block_ordered, clk, rst, cells.valid && cells.write_enable,
                  cells.x_first <= cells.x_final && cells.y_first <= cells.y_final)

endmodule
